>>> rtl/ohm_pkg.sv
// Shared types and constants of the ordered hash map.
// Holds request and status codes, the datapath operation codes, the controller
// states and the command and status structs. Depends on nothing.
`default_nettype none
package ohm_pkg;

  // request actions
  localparam logic [2:0] ACT_GET       = 3'd0;
  localparam logic [2:0] ACT_PUT       = 3'd1;
  localparam logic [2:0] ACT_DELETE    = 3'd2;
  localparam logic [2:0] ACT_CLEAR     = 3'd3;
  localparam logic [2:0] ACT_ITER_BEG  = 3'd4;
  localparam logic [2:0] ACT_ITER_END  = 3'd5;
  localparam logic [2:0] ACT_ITER_NEXT = 3'd6;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_END  = 2'd3;

  // splitmix64 finalizer
  localparam logic [63:0] HASH_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] HASH_C2 = 64'h94d049bb133111eb;
  localparam int HASH_S1 = 30;
  localparam int HASH_S2 = 27;
  localparam int HASH_S3 = 31;

  // entry word: {live, key, value}
  localparam int ENT_W = 129;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_HASH_REQ, OP_HASH_ENT, OP_PROBE_INIT, OP_SLOT_RD,
    OP_SLOT_CHK, OP_ENT_CHK, OP_PROBE_ADV, OP_SWEEP, OP_CLR_CNT, OP_CP_INIT,
    OP_CP_RD, OP_CP_WR, OP_CP_END, OP_RB_RD, OP_RB_SLOT, OP_PUT_UPD, OP_PUT_NEW,
    OP_DEL, OP_ITER_B, OP_ITER_E, OP_ITN_INIT, OP_ITN_RD, OP_ITN_CHK, OP_RESULT
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_HASH, S_SLOT_RD, S_SLOT_CHK, S_ENT_CHK, S_ADV,
    S_FOUND, S_SWEEP, S_CP_RD, S_CP_WR, S_RB_RD, S_RB_HASH, S_ITN_RD,
    S_ITN_CHK, S_RESP
  } ohm_state_t;

  // what a finished probe or sweep returns to
  typedef enum logic [2:0] {
    CTX_REQ, CTX_RB, CTX_PUT2, CTX_RST, CTX_CLR, CTX_CP
  } ohm_ctx_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] res;
  } dp_cmd_t;

  typedef struct packed {
    logic       hash_done;
    logic       slot_empty;
    logic       slot_ref;
    logic       ent_match;
    logic       ent_live;
    logic       probe_last;
    logic       hit;
    logic       where_ok;
    logic       sweep_last;
    logic       cp_more;
    logic       rb_more;
    logic       itn_more;
    logic       used_full;
    logic       iters_zero;
    logic       out_busy;
    logic [2:0] act;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> rtl/ohm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module ohm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/ohm_hash.sv
// Multi-cycle splitmix64 finalizer built on one shared 32x32 multiplier.
// Each 64-bit product takes three partial products; done pulses when hash_out holds the result.
// Depends on ohm_pkg.
`default_nettype none
module ohm_hash (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] key_in,
  output logic             done,
  output logic      [63:0] hash_out
);

  logic [63:0] x_r, x_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] p_r, p_nxt;
  logic [63:0] h_r, h_nxt;
  logic [2:0]  ph_r, ph_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [1:0]  j;
  logic [63:0] c;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod, sum;

  assign j     = ph_r[1:0];
  assign c     = ph_r[2] ? ohm_pkg::HASH_C2 : ohm_pkg::HASH_C1;
  assign mul_a = (j == 2'd2) ? x_r[63:32] : x_r[31:0];
  assign mul_b = (j == 2'd1) ? c[63:32] : c[31:0];
  assign prod  = {32'b0, mul_a} * {32'b0, mul_b};
  assign sum   = acc_r + {p_r[31:0], 32'b0};

  always_comb begin
    x_nxt    = x_r;
    acc_nxt  = acc_r;
    p_nxt    = p_r;
    h_nxt    = h_r;
    ph_nxt   = ph_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt    = key_in ^ (key_in >> ohm_pkg::HASH_S1);
      ph_nxt   = 3'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      p_nxt  = prod;
      ph_nxt = ph_r + 3'd1;
      case (j)
        2'd1: acc_nxt = p_r;
        2'd2: acc_nxt = {acc_r[63:32] + p_r[31:0], acc_r[31:0]};
        2'd3: begin
          if (ph_r[2]) begin
            h_nxt    = sum ^ (sum >> ohm_pkg::HASH_S3);
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end else begin
            x_nxt = sum ^ (sum >> ohm_pkg::HASH_S2);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      ph_r   <= ph_nxt;
    end
    x_r   <= x_nxt;
    acc_r <= acc_nxt;
    p_r   <= p_nxt;
    h_r   <= h_nxt;
  end

  assign done     = done_r;
  assign hash_out = h_r;

endmodule
`default_nettype wire

>>> rtl/ohm_datapath.sv
// Datapath of the ordered hash map: request latch, counters, probe pointers,
// entry and slot memories, hash unit and the result register.
// Depends on ohm_pkg, ohm_ram and ohm_hash.
`default_nettype none
module ohm_datapath #(
  parameter int ENTRY_CAPACITY = 256,
  parameter int SLOT_COUNT     = 512,
  localparam int CW  = $clog2(ENTRY_CAPACITY + 1),
  localparam int EW  = $clog2(ENTRY_CAPACITY),
  localparam int SW  = $clog2(SLOT_COUNT),
  localparam int ITW = ((128 + CW + 7) / 8) * 8,
  localparam int OTW = ((128 + 2 * CW + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ohm_pkg::dp_cmd_t cmd,
  output ohm_pkg::dp_stat_t     stat,
  input  wire logic [2:0]       in_tuser,
  input  wire logic [ITW-1:0]   in_tdata,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic      [1:0]       out_tuser,
  output logic      [OTW-1:0]   out_tdata
);

  logic [2:0]  act_r, act_nxt;
  logic [63:0] key_r, key_nxt, data_r, data_nxt, pk_r, pk_nxt;
  logic [CW-1:0] cur_r, cur_nxt;
  logic [SW-1:0] sp_r, sp_nxt, pn_r, pn_nxt, where_r, where_nxt, sw_r, sw_nxt;
  logic        where_ok_r, where_ok_nxt, hit_r, hit_nxt;
  logic [EW-1:0] hit_e_r, hit_e_nxt;
  logic [63:0] hitval_r, hitval_nxt, fk_r, fk_nxt, fv_r, fv_nxt;
  logic [CW-1:0] used_r, used_nxt, live_r, live_nxt;
  logic [CW-1:0] src_r, src_nxt, dst_r, dst_nxt, rb_r, rb_nxt, c_r, c_nxt;
  logic [7:0]  iters_r, iters_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_st_r, out_st_nxt;
  logic [63:0] out_fk_r, out_fk_nxt, out_fv_r, out_fv_nxt;
  logic [CW-1:0] out_nc_r, out_nc_nxt, out_cnt_r, out_cnt_nxt;

  logic          slot_we, slot_re;
  logic [SW-1:0] slot_waddr, slot_raddr;
  logic [CW-1:0] slot_wdata, slot_rdata, held_m1;
  logic          ent_we, ent_re;
  logic [EW-1:0] ent_waddr, ent_raddr;
  logic [ohm_pkg::ENT_W-1:0] ent_wdata, ent_rdata;
  logic          ent_rlive;
  logic [63:0]   ent_rkey, ent_rval;

  logic        hash_start, hash_done;
  logic [63:0] hash_src, hash_val;
  logic        is_itn_ok;

  assign ent_rlive = ent_rdata[128];
  assign ent_rkey  = ent_rdata[127:64];
  assign ent_rval  = ent_rdata[63:0];
  assign held_m1   = slot_rdata - CW'(1);

  ohm_ram #(.WIDTH(CW), .DEPTH(SLOT_COUNT)) u_slot_ram (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .re(slot_re), .raddr(slot_raddr), .rdata(slot_rdata)
  );

  ohm_ram #(.WIDTH(ohm_pkg::ENT_W), .DEPTH(ENTRY_CAPACITY)) u_ent_ram (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
    .re(ent_re), .raddr(ent_raddr), .rdata(ent_rdata)
  );

  ohm_hash u_hash (
    .clk(clk), .rst_n(rst_n), .start(hash_start), .key_in(hash_src),
    .done(hash_done), .hash_out(hash_val)
  );

  always_comb begin
    stat.hash_done  = hash_done;
    stat.slot_empty = (slot_rdata == '0);
    stat.slot_ref   = (slot_rdata <= CW'(ENTRY_CAPACITY));
    stat.ent_match  = ent_rlive && (ent_rkey == pk_r);
    stat.ent_live   = ent_rlive;
    stat.probe_last = (pn_r == SW'(SLOT_COUNT - 1));
    stat.hit        = hit_r;
    stat.where_ok   = where_ok_r;
    stat.sweep_last = (sw_r == SW'(SLOT_COUNT - 1));
    stat.cp_more    = (src_r < used_r);
    stat.rb_more    = (rb_r < used_r);
    stat.itn_more   = (c_r < used_r);
    stat.used_full  = (used_r >= CW'(ENTRY_CAPACITY));
    stat.iters_zero = (iters_r == 8'd0);
    stat.out_busy   = out_valid_r && !out_tready;
    stat.act        = act_r;
  end

  assign is_itn_ok = (act_r == ohm_pkg::ACT_ITER_NEXT) && (cmd.res == ohm_pkg::ST_OK);

  always_comb begin
    act_nxt      = act_r;
    key_nxt      = key_r;
    data_nxt     = data_r;
    cur_nxt      = cur_r;
    pk_nxt       = pk_r;
    sp_nxt       = sp_r;
    pn_nxt       = pn_r;
    where_nxt    = where_r;
    where_ok_nxt = where_ok_r;
    hit_nxt      = hit_r;
    hit_e_nxt    = hit_e_r;
    hitval_nxt   = hitval_r;
    fk_nxt       = fk_r;
    fv_nxt       = fv_r;
    used_nxt     = used_r;
    live_nxt     = live_r;
    src_nxt      = src_r;
    dst_nxt      = dst_r;
    rb_nxt       = rb_r;
    c_nxt        = c_r;
    sw_nxt       = sw_r;
    iters_nxt    = iters_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_st_nxt   = out_st_r;
    out_fk_nxt   = out_fk_r;
    out_fv_nxt   = out_fv_r;
    out_nc_nxt   = out_nc_r;
    out_cnt_nxt  = out_cnt_r;
    slot_we      = 1'b0;
    slot_waddr   = where_r;
    slot_wdata   = '0;
    slot_re      = 1'b0;
    slot_raddr   = sp_r;
    ent_we       = 1'b0;
    ent_waddr    = hit_e_r;
    ent_wdata    = {1'b1, key_r, data_r};
    ent_re       = 1'b0;
    ent_raddr    = held_m1[EW-1:0];
    hash_start   = 1'b0;
    hash_src     = key_r;

    case (cmd.op)
      ohm_pkg::OP_LATCH: begin
        act_nxt  = in_tuser;
        key_nxt  = in_tdata[63:0];
        data_nxt = in_tdata[127:64];
        cur_nxt  = in_tdata[128 +: CW];
      end
      ohm_pkg::OP_HASH_REQ: begin
        pk_nxt     = key_r;
        hash_start = 1'b1;
      end
      ohm_pkg::OP_HASH_ENT: begin
        pk_nxt     = ent_rkey;
        hash_src   = ent_rkey;
        hash_start = 1'b1;
      end
      ohm_pkg::OP_PROBE_INIT: begin
        sp_nxt       = hash_val[SW-1:0];
        pn_nxt       = '0;
        hit_nxt      = 1'b0;
        where_ok_nxt = 1'b0;
      end
      ohm_pkg::OP_SLOT_RD: slot_re = 1'b1;
      ohm_pkg::OP_SLOT_CHK: begin
        ent_re = 1'b1;
        if (stat.slot_empty) begin
          where_nxt    = sp_r;
          where_ok_nxt = 1'b1;
        end
      end
      ohm_pkg::OP_ENT_CHK: begin
        if (stat.ent_match) begin
          hit_nxt    = 1'b1;
          where_nxt  = sp_r;
          hit_e_nxt  = held_m1[EW-1:0];
          hitval_nxt = ent_rval;
        end
      end
      ohm_pkg::OP_PROBE_ADV: begin
        sp_nxt = sp_r + SW'(1);
        pn_nxt = pn_r + SW'(1);
      end
      ohm_pkg::OP_SWEEP: begin
        slot_we    = 1'b1;
        slot_waddr = sw_r;
        sw_nxt     = sw_r + SW'(1);
      end
      ohm_pkg::OP_CLR_CNT: begin
        used_nxt = '0;
        live_nxt = '0;
        sw_nxt   = '0;
      end
      ohm_pkg::OP_CP_INIT: begin
        src_nxt = '0;
        dst_nxt = '0;
      end
      ohm_pkg::OP_CP_RD: begin
        ent_re    = 1'b1;
        ent_raddr = src_r[EW-1:0];
        src_nxt   = src_r + CW'(1);
      end
      ohm_pkg::OP_CP_WR: begin
        // dst never passes src, so moved entries are already read
        if (ent_rlive) begin
          ent_we    = 1'b1;
          ent_waddr = dst_r[EW-1:0];
          ent_wdata = ent_rdata;
          dst_nxt   = dst_r + CW'(1);
        end
      end
      ohm_pkg::OP_CP_END: begin
        used_nxt = dst_r;
        live_nxt = dst_r;
        sw_nxt   = '0;
        rb_nxt   = '0;
      end
      ohm_pkg::OP_RB_RD: begin
        ent_re    = 1'b1;
        ent_raddr = rb_r[EW-1:0];
      end
      ohm_pkg::OP_RB_SLOT: begin
        if (where_ok_r) begin
          slot_we    = 1'b1;
          slot_wdata = rb_r + CW'(1);
        end
        rb_nxt = rb_r + CW'(1);
      end
      ohm_pkg::OP_PUT_UPD: ent_we = 1'b1;
      ohm_pkg::OP_PUT_NEW: begin
        ent_we     = 1'b1;
        ent_waddr  = used_r[EW-1:0];
        slot_we    = 1'b1;
        slot_wdata = used_r + CW'(1);
        used_nxt   = used_r + CW'(1);
        live_nxt   = live_r + CW'(1);
      end
      ohm_pkg::OP_DEL: begin
        ent_we    = 1'b1;
        ent_wdata = '0;
        if (live_r != '0) begin
          live_nxt = live_r - CW'(1);
        end
      end
      ohm_pkg::OP_ITER_B: if (iters_r != 8'hFF) iters_nxt = iters_r + 8'd1;
      ohm_pkg::OP_ITER_E: if (iters_r != 8'd0) iters_nxt = iters_r - 8'd1;
      ohm_pkg::OP_ITN_INIT: c_nxt = cur_r;
      ohm_pkg::OP_ITN_RD: begin
        ent_re    = 1'b1;
        ent_raddr = c_r[EW-1:0];
        c_nxt     = c_r + CW'(1);
      end
      ohm_pkg::OP_ITN_CHK: begin
        fk_nxt = ent_rkey;
        fv_nxt = ent_rval;
      end
      ohm_pkg::OP_RESULT: begin
        out_valid_nxt = 1'b1;
        out_st_nxt    = cmd.res;
        out_fk_nxt    = is_itn_ok ? fk_r : 64'd0;
        if (is_itn_ok) begin
          out_fv_nxt = fv_r;
        end else if ((act_r == ohm_pkg::ACT_GET) && (cmd.res == ohm_pkg::ST_OK)) begin
          out_fv_nxt = hitval_r;
        end else begin
          out_fv_nxt = 64'd0;
        end
        out_nc_nxt  = (act_r == ohm_pkg::ACT_ITER_NEXT) ? c_r : '0;
        out_cnt_nxt = live_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      live_r      <= '0;
      iters_r     <= '0;
      sw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      live_r      <= live_nxt;
      iters_r     <= iters_nxt;
      sw_r        <= sw_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r      <= act_nxt;
    key_r      <= key_nxt;
    data_r     <= data_nxt;
    cur_r      <= cur_nxt;
    pk_r       <= pk_nxt;
    sp_r       <= sp_nxt;
    pn_r       <= pn_nxt;
    where_r    <= where_nxt;
    where_ok_r <= where_ok_nxt;
    hit_r      <= hit_nxt;
    hit_e_r    <= hit_e_nxt;
    hitval_r   <= hitval_nxt;
    fk_r       <= fk_nxt;
    fv_r       <= fv_nxt;
    src_r      <= src_nxt;
    dst_r      <= dst_nxt;
    rb_r       <= rb_nxt;
    c_r        <= c_nxt;
    out_st_r   <= out_st_nxt;
    out_fk_r   <= out_fk_nxt;
    out_fv_r   <= out_fv_nxt;
    out_nc_r   <= out_nc_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = OTW'({out_cnt_r, out_nc_r, out_fv_r, out_fk_r});

endmodule
`default_nettype wire

>>> rtl/ohm_ctrl.sv
// Controller state machine of the ordered hash map: sequences hashing, probing,
// sweeps, compaction, rebuild and iteration. Depends on ohm_pkg.
`default_nettype none
module ohm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire ohm_pkg::dp_stat_t st,
  output ohm_pkg::dp_cmd_t       cmd
);

  ohm_pkg::ohm_state_t state_r, state_nxt;
  ohm_pkg::ohm_ctx_t   ctx_r, ctx_nxt;
  logic [1:0]          res_r, res_nxt;

  // next state, probe context and pending status
  always_comb begin
    state_nxt = state_r;
    ctx_nxt   = ctx_r;
    res_nxt   = res_r;
    unique case (state_r)
      ohm_pkg::S_IDLE: if (in_tvalid) state_nxt = ohm_pkg::S_DISPATCH;
      ohm_pkg::S_DISPATCH: begin
        res_nxt = ohm_pkg::ST_OK;
        unique case (st.act) inside
          ohm_pkg::ACT_GET, ohm_pkg::ACT_PUT, ohm_pkg::ACT_DELETE: begin
            ctx_nxt   = ohm_pkg::CTX_REQ;
            state_nxt = ohm_pkg::S_HASH;
          end
          ohm_pkg::ACT_CLEAR: begin
            ctx_nxt   = ohm_pkg::CTX_CLR;
            state_nxt = ohm_pkg::S_SWEEP;
          end
          ohm_pkg::ACT_ITER_NEXT: state_nxt = ohm_pkg::S_ITN_RD;
          default: state_nxt = ohm_pkg::S_RESP;
        endcase
      end
      ohm_pkg::S_HASH: if (st.hash_done) state_nxt = ohm_pkg::S_SLOT_RD;
      ohm_pkg::S_SLOT_RD: state_nxt = ohm_pkg::S_SLOT_CHK;
      ohm_pkg::S_SLOT_CHK: begin
        if (st.slot_empty) begin
          state_nxt = ohm_pkg::S_FOUND;
        end else if (st.slot_ref) begin
          state_nxt = ohm_pkg::S_ENT_CHK;
        end else begin
          state_nxt = ohm_pkg::S_ADV;
        end
      end
      ohm_pkg::S_ENT_CHK: state_nxt = st.ent_match ? ohm_pkg::S_FOUND : ohm_pkg::S_ADV;
      ohm_pkg::S_ADV: state_nxt = st.probe_last ? ohm_pkg::S_FOUND : ohm_pkg::S_SLOT_RD;
      ohm_pkg::S_FOUND: begin
        state_nxt = ohm_pkg::S_RESP;
        unique case (ctx_r)
          ohm_pkg::CTX_RB: state_nxt = ohm_pkg::S_RB_RD;
          ohm_pkg::CTX_PUT2: res_nxt = st.where_ok ? ohm_pkg::ST_OK : ohm_pkg::ST_FULL;
          default: begin
            if (st.act == ohm_pkg::ACT_PUT) begin
              if (st.hit) begin
                res_nxt = ohm_pkg::ST_OK;
              end else if (st.used_full && st.iters_zero) begin
                ctx_nxt   = ohm_pkg::CTX_CP;
                state_nxt = ohm_pkg::S_CP_RD;
              end else if (st.used_full || !st.where_ok) begin
                res_nxt = ohm_pkg::ST_FULL;
              end else begin
                res_nxt = ohm_pkg::ST_OK;
              end
            end else begin
              res_nxt = st.hit ? ohm_pkg::ST_OK : ohm_pkg::ST_MISS;
            end
          end
        endcase
      end
      ohm_pkg::S_SWEEP: begin
        if (st.sweep_last) begin
          unique case (ctx_r)
            ohm_pkg::CTX_RST: state_nxt = ohm_pkg::S_IDLE;
            ohm_pkg::CTX_CP:  state_nxt = ohm_pkg::S_RB_RD;
            default:          state_nxt = ohm_pkg::S_RESP;
          endcase
        end
      end
      ohm_pkg::S_CP_RD: begin
        if (st.cp_more) begin
          state_nxt = ohm_pkg::S_CP_WR;
        end else begin
          state_nxt = ohm_pkg::S_SWEEP;
        end
      end
      ohm_pkg::S_CP_WR: state_nxt = ohm_pkg::S_CP_RD;
      ohm_pkg::S_RB_RD: begin
        if (st.rb_more) begin
          state_nxt = ohm_pkg::S_RB_HASH;
        end else if (st.used_full) begin
          res_nxt   = ohm_pkg::ST_FULL;
          state_nxt = ohm_pkg::S_RESP;
        end else begin
          ctx_nxt   = ohm_pkg::CTX_PUT2;
          state_nxt = ohm_pkg::S_HASH;
        end
      end
      ohm_pkg::S_RB_HASH: begin
        ctx_nxt   = ohm_pkg::CTX_RB;
        state_nxt = ohm_pkg::S_HASH;
      end
      ohm_pkg::S_ITN_RD: begin
        if (st.itn_more) begin
          state_nxt = ohm_pkg::S_ITN_CHK;
        end else begin
          res_nxt   = ohm_pkg::ST_END;
          state_nxt = ohm_pkg::S_RESP;
        end
      end
      ohm_pkg::S_ITN_CHK: begin
        if (st.ent_live) begin
          res_nxt   = ohm_pkg::ST_OK;
          state_nxt = ohm_pkg::S_RESP;
        end else begin
          state_nxt = ohm_pkg::S_ITN_RD;
        end
      end
      ohm_pkg::S_RESP: if (!st.out_busy) state_nxt = ohm_pkg::S_IDLE;
      default: state_nxt = ohm_pkg::S_IDLE;
    endcase
  end

  // datapath command for the current state
  always_comb begin
    cmd.op    = ohm_pkg::OP_NONE;
    cmd.res   = res_r;
    in_tready = (state_r == ohm_pkg::S_IDLE);
    unique case (state_r)
      ohm_pkg::S_IDLE: if (in_tvalid) cmd.op = ohm_pkg::OP_LATCH;
      ohm_pkg::S_DISPATCH: begin
        unique case (st.act) inside
          ohm_pkg::ACT_GET, ohm_pkg::ACT_PUT, ohm_pkg::ACT_DELETE:
            cmd.op = ohm_pkg::OP_HASH_REQ;
          ohm_pkg::ACT_CLEAR:     cmd.op = ohm_pkg::OP_CLR_CNT;
          ohm_pkg::ACT_ITER_BEG:  cmd.op = ohm_pkg::OP_ITER_B;
          ohm_pkg::ACT_ITER_END:  cmd.op = ohm_pkg::OP_ITER_E;
          ohm_pkg::ACT_ITER_NEXT: cmd.op = ohm_pkg::OP_ITN_INIT;
          default:                cmd.op = ohm_pkg::OP_NONE;
        endcase
      end
      ohm_pkg::S_HASH:     if (st.hash_done) cmd.op = ohm_pkg::OP_PROBE_INIT;
      ohm_pkg::S_SLOT_RD:  cmd.op = ohm_pkg::OP_SLOT_RD;
      ohm_pkg::S_SLOT_CHK: cmd.op = ohm_pkg::OP_SLOT_CHK;
      ohm_pkg::S_ENT_CHK:  cmd.op = ohm_pkg::OP_ENT_CHK;
      ohm_pkg::S_ADV:      cmd.op = ohm_pkg::OP_PROBE_ADV;
      ohm_pkg::S_FOUND: begin
        unique case (ctx_r)
          ohm_pkg::CTX_RB: cmd.op = ohm_pkg::OP_RB_SLOT;
          ohm_pkg::CTX_PUT2: if (st.where_ok) cmd.op = ohm_pkg::OP_PUT_NEW;
          default: begin
            if (st.act == ohm_pkg::ACT_PUT) begin
              if (st.hit) begin
                cmd.op = ohm_pkg::OP_PUT_UPD;
              end else if (st.used_full) begin
                if (st.iters_zero) cmd.op = ohm_pkg::OP_CP_INIT;
              end else if (st.where_ok) begin
                cmd.op = ohm_pkg::OP_PUT_NEW;
              end
            end else if (st.act == ohm_pkg::ACT_DELETE && st.hit) begin
              cmd.op = ohm_pkg::OP_DEL;
            end
          end
        endcase
      end
      ohm_pkg::S_SWEEP:   cmd.op = ohm_pkg::OP_SWEEP;
      ohm_pkg::S_CP_RD:   cmd.op = st.cp_more ? ohm_pkg::OP_CP_RD : ohm_pkg::OP_CP_END;
      ohm_pkg::S_CP_WR:   cmd.op = ohm_pkg::OP_CP_WR;
      ohm_pkg::S_RB_RD: begin
        if (st.rb_more) begin
          cmd.op = ohm_pkg::OP_RB_RD;
        end else if (!st.used_full) begin
          cmd.op = ohm_pkg::OP_HASH_REQ;
        end
      end
      ohm_pkg::S_RB_HASH: cmd.op = ohm_pkg::OP_HASH_ENT;
      ohm_pkg::S_ITN_RD:  if (st.itn_more) cmd.op = ohm_pkg::OP_ITN_RD;
      ohm_pkg::S_ITN_CHK: cmd.op = ohm_pkg::OP_ITN_CHK;
      ohm_pkg::S_RESP:    if (!st.out_busy) cmd.op = ohm_pkg::OP_RESULT;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // clear the slot table before the first request
      state_r <= ohm_pkg::S_SWEEP;
      ctx_r   <= ohm_pkg::CTX_RST;
      res_r   <= ohm_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      ctx_r   <= ctx_nxt;
      res_r   <= res_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/ordered_hash_map.sv
// Top level of the insertion-ordered hash map: controller plus datapath.
// Depends on ohm_pkg, ohm_ctrl and ohm_datapath.
//
// Usage: one request on the in_ stream gives exactly one result on the out_
// stream, in order. A request is taken only while the engine is idle; it then
// runs alone until its result sits in the output register.
// Iter begin, iter end and unknown actions go from dispatch straight to the
// result. A get, put or delete hashes the key on one shared 32x32 multiplier,
// then probes slots from the hash value (slot read, slot check, an entry
// check for an occupied slot, advance) until an empty slot, a hit or a pass
// over the whole slot table. Iter next scans entries from the cursor until a
// live entry or the end of the used entries. Clear sweeps the whole slot
// table. A put into a full entry array with no open iteration first compacts
// the live entries, sweeps the slot table and rehashes every live entry.
// Reset: synchronous; after rst_n rises the whole slot table is swept while
// in_tready stays low.
// Stall: the result holds in out_tdata/out_tuser while out_tready is low; the
// next request is accepted meanwhile, and its result waits until the
// register frees.
`default_nettype none
module ordered_hash_map #(
  parameter int ENTRY_CAPACITY = 256,
  parameter int SLOT_COUNT     = 512,
  localparam int CW  = $clog2(ENTRY_CAPACITY + 1),
  localparam int ITW = ((128 + CW + 7) / 8) * 8,
  localparam int OTW = ((128 + 2 * CW + 7) / 8) * 8
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic [ITW-1:0] in_tdata,   // key_word, data_word, cursor
  input  wire logic [2:0]     in_tuser,   // action
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic      [OTW-1:0] out_tdata,  // found_key, found_value, next_cursor, entry_count
  output logic      [1:0]     out_tuser   // status
);

  ohm_pkg::dp_cmd_t  cmd;
  ohm_pkg::dp_stat_t stat;

  ohm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .st(stat), .cmd(cmd)
  );

  ohm_datapath #(.ENTRY_CAPACITY(ENTRY_CAPACITY), .SLOT_COUNT(SLOT_COUNT)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tuser(out_tuser), .out_tdata(out_tdata)
  );

endmodule
`default_nettype wire

>>> rtl/ohm_checker.sv
// Port-level checks of the ordered hash map, bound to the top level.
// Depends on ordered_hash_map's ports only.
`default_nettype none
module ohm_checker #(
  parameter int ENTRY_CAPACITY = 256,
  localparam int CW  = $clog2(ENTRY_CAPACITY + 1),
  localparam int OTW = ((128 + 2 * CW + 7) / 8) * 8
) (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_tvalid,
  input wire logic           in_tready,
  input wire logic           out_tvalid,
  input wire logic           out_tready,
  input wire logic [OTW-1:0] out_tdata,
  input wire logic [1:0]     out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // one request at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while engine busy");

  // live count never exceeds the entry array
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[128 + CW +: CW] <= CW'(ENTRY_CAPACITY))
    else $error("entry count out of range");

  // reset drops any pending result and blocks requests
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("outputs active after reset");

endmodule

bind ordered_hash_map ohm_checker #(.ENTRY_CAPACITY(ENTRY_CAPACITY)) u_ohm_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);
`default_nettype wire
